### rtl/scps_pkg.sv
// Shared types and constants for the spotlight cone pixel shader.
package scps_pkg;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef enum logic [1:0] {
    REG_CONE_HALF_ANGLE = 2'd0,
    REG_CONE_INVERSE    = 2'd1,
    REG_REACH_INVERSE   = 2'd2
  } cfg_reg_e;

  localparam logic [15:0] CONE_HALF_ANGLE_RST = 16'd5461;
  localparam logic [31:0] CONE_INVERSE_RST    = 32'd786432;
  localparam logic [31:0] REACH_INVERSE_RST   = 32'd65536;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

### rtl/spotlight_cone_pixel_shader.sv
// Path from input request to output request: factor stages 1 to 4, then the output register.
// Throughput: one pixel per cycle while the output accepts; stages collapse bubbles while the output stalls.
// Cost per pixel is set by the multiplier chain: distance, angle, square, total, channel.
// Reset (async, active low) empties the pipeline and loads the default cone and reach.
// Three channel lanes scale in parallel; the output register merges them with alpha.
module spotlight_cone_pixel_shader #(
  parameter int FactorBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red_in, green_in, blue_in, alpha_in, ray_bam, facing_angle, hit_distance
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [31:0] m_axis_tdata,
  // inside_cone
  output logic        m_axis_tuser
);
  import scps_pkg::*;

  logic [15:0] cone_half_q;
  logic [31:0] cone_inv_q;
  logic [31:0] reach_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_half_q <= CONE_HALF_ANGLE_RST;
      cone_inv_q  <= CONE_INVERSE_RST;
      reach_inv_q <= REACH_INVERSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CONE_HALF_ANGLE: cone_half_q <= cfg_wdata_i[15:0];
        REG_CONE_INVERSE:    cone_inv_q  <= cfg_wdata_i;
        REG_REACH_INVERSE:   reach_inv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pixel_t              pix_in;
  pixel_t              f_pix;
  logic                f_valid;
  logic                f_inside;
  logic [FactorBits:0] f_total;
  logic                out_en;

  assign pix_in = s_axis_tdata[31:0];

  scps_factor #(
    .FactorBits(FactorBits)
  ) u_factor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cone_half_angle_i(cone_half_q),
    .cone_inverse_i   (cone_inv_q),
    .reach_inverse_i  (reach_inv_q),
    .valid_i          (s_axis_tvalid),
    .ready_o          (s_axis_tready),
    .pixel_i          (pix_in),
    .ray_bam_i        (s_axis_tdata[47:32]),
    .facing_angle_i   (s_axis_tdata[63:48]),
    .hit_distance_i   (s_axis_tdata[79:64]),
    .valid_o          (f_valid),
    .ready_i          (out_en),
    .pixel_o          (f_pix),
    .inside_o         (f_inside),
    .total_o          (f_total)
  );

  logic [7:0] red_l, green_l, blue_l;

  scps_chan_lane #(.FactorBits(FactorBits)) u_lane_red (
    .chan_i(f_pix.red), .total_i(f_total), .inside_i(f_inside), .chan_o(red_l)
  );
  scps_chan_lane #(.FactorBits(FactorBits)) u_lane_green (
    .chan_i(f_pix.green), .total_i(f_total), .inside_i(f_inside), .chan_o(green_l)
  );
  scps_chan_lane #(.FactorBits(FactorBits)) u_lane_blue (
    .chan_i(f_pix.blue), .total_i(f_total), .inside_i(f_inside), .chan_o(blue_l)
  );

  // merge stage / output register
  logic   out_valid_q;
  pixel_t out_pix_q;
  logic   out_inside_q;

  assign out_en = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_pix_q.red   <= red_l;
      out_pix_q.green <= green_l;
      out_pix_q.blue  <= blue_l;
      out_pix_q.alpha <= f_inside ? f_pix.alpha : ALPHA_OPAQUE;
      out_inside_q    <= f_inside;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_inside_q;

endmodule

### rtl/scps_factor.sv
// Four-stage front end: cone test, angular and distance falloff, total light factor.
module scps_factor #(
  parameter int FactorBits = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [15:0]             cone_half_angle_i,
  input  logic [31:0]             cone_inverse_i,
  input  logic [31:0]             reach_inverse_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  scps_pkg::pixel_t        pixel_i,
  input  logic [15:0]             ray_bam_i,
  input  logic [15:0]             facing_angle_i,
  input  logic [15:0]             hit_distance_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output scps_pkg::pixel_t        pixel_o,
  output logic                    inside_o,
  output logic [FactorBits:0]     total_o
);
  import scps_pkg::*;

  localparam int FW = FactorBits + 1;
  localparam int SH = 32 - FactorBits;
  localparam logic [FactorBits:0] ONE = {1'b1, {FactorBits{1'b0}}};

  // per-stage valid and advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: angle magnitude, cone test, distance product
  logic [15:0] diff;
  logic [16:0] mag1_d;
  logic        in1_d;
  logic [47:0] dist_prod;
  logic [15+FactorBits:0] r1_d;

  assign diff      = ray_bam_i - facing_angle_i;
  assign mag1_d    = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
  assign in1_d     = mag1_d < {1'b0, cone_half_angle_i};
  assign dist_prod = {32'd0, hit_distance_i} * {16'd0, reach_inverse_i};
  assign r1_d      = dist_prod[47:SH];

  pixel_t                 pix1_q;
  logic [16:0]            mag1_q;
  logic                   in1_q;
  logic [15+FactorBits:0] r1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pix1_q <= pixel_i;
      mag1_q <= mag1_d;
      in1_q  <= in1_d;
      r1_q   <= r1_d;
    end
  end

  // stage 2: angle product, distance falloff
  logic [48:0]            ang_prod;
  logic [16+FactorBits:0] q2_d;
  logic [FactorBits:0]    d2_d;

  assign ang_prod = {32'd0, mag1_q} * {17'd0, cone_inverse_i};
  assign q2_d     = ang_prod[48:SH];
  assign d2_d     = (|r1_q[15+FactorBits:FactorBits]) ? '0
                  : ONE - {1'b0, r1_q[FactorBits-1:0]};

  pixel_t                 pix2_q;
  logic                   in2_q;
  logic [16+FactorBits:0] q2_q;
  logic [FactorBits:0]    d2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pix2_q <= pix1_q;
      in2_q  <= in1_q;
      q2_q   <= q2_d;
      d2_q   <= d2_d;
    end
  end

  // stage 3: angular falloff, squared
  logic [FactorBits:0] ang;
  logic [2*FW-1:0]     sq;

  assign ang = (|q2_q[16+FactorBits:FactorBits]) ? '0
             : ONE - {1'b0, q2_q[FactorBits-1:0]};
  assign sq  = {{FW{1'b0}}, ang} * {{FW{1'b0}}, ang};

  pixel_t              pix3_q;
  logic                in3_q;
  logic [FactorBits:0] a3_q;
  logic [FactorBits:0] d3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pix3_q <= pix2_q;
      in3_q  <= in2_q;
      a3_q   <= sq[2*FactorBits:FactorBits];
      d3_q   <= d2_q;
    end
  end

  // stage 4: total light factor
  logic [2*FW-1:0] tp;
  assign tp = {{FW{1'b0}}, a3_q} * {{FW{1'b0}}, d3_q};

  pixel_t              pix4_q;
  logic                in4_q;
  logic [FactorBits:0] t4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pix4_q <= pix3_q;
      in4_q  <= in3_q;
      t4_q   <= tp[2*FactorBits:FactorBits];
    end
  end

  assign valid_o  = v4_q;
  assign pixel_o  = pix4_q;
  assign inside_o = in4_q;
  assign total_o  = t4_q;

endmodule

### rtl/scps_chan_lane.sv
// One color channel lane: scales a channel by the light factor, black outside the cone.
module scps_chan_lane #(
  parameter int FactorBits = 16
) (
  input  logic [7:0]          chan_i,
  input  logic [FactorBits:0] total_i,
  input  logic                inside_i,
  output logic [7:0]          chan_o
);
  localparam int PW = FactorBits + 9;

  logic [PW-1:0] prod;

  assign prod   = {{(FactorBits+1){1'b0}}, chan_i} * {8'd0, total_i};
  assign chan_o = inside_i ? prod[FactorBits+7:FactorBits] : 8'd0;

endmodule

### rtl/scps_checker.sv
// Port-level checks for the spotlight cone pixel shader, bound to the top level.
module scps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled request keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output request dropped or changed while stalled");

  // an empty output stage means the pipeline cannot be blocked
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // outside the cone: opaque black
  a_outside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'hFF00_0000))
    else $error("outside-cone pixel not opaque black");

  // an accepted request reaches the output through every pipeline register when the sink keeps taking
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(s_acc, 5) && $past(m_axis_tready, 4) && $past(m_axis_tready, 3)
     && $past(m_axis_tready, 2) && $past(m_axis_tready, 1)) |-> m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind spotlight_cone_pixel_shader scps_checker u_scps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
